// ===== rtl/core/arp_pkg.sv =====
// Shared types and codes for the AArch64 relocation patcher.
// Used by every stage module and by the top level; no dependencies.
package arp_pkg;

  localparam logic [31:0] R_PAGE_HI21 = 32'd275;
  localparam logic [31:0] R_ADD_LO12  = 32'd277;
  localparam logic [31:0] R_CALL26    = 32'd283;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CALL = 2'd1;
  localparam logic [1:0] KIND_PAGE = 2'd2;
  localparam logic [1:0] KIND_LO12 = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BR_ALIGN  = 3'd1;
  localparam logic [2:0] ST_BR_RANGE  = 3'd2;
  localparam logic [2:0] ST_PG_RANGE  = 3'd3;
  localparam logic [2:0] ST_LO12_FAIL = 3'd4;

  localparam logic [31:0] BR_KEEP_MASK = 32'hfc00_0000;
  localparam logic [4:0]  ADD_IMM_OPC  = 5'b10001;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] word;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [11:0] lo12;
  } dec_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] word;
    logic [63:0] diff;
    logic [11:0] lo12;
  } sub_t;

endpackage

// ===== rtl/core/arp_decode.sv =====
// Stage 1: classify the relocation type and select subtract operands.
// Depends on arp_pkg.
module arp_decode
  import arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [31:0] in_action,
  input  logic [31:0] in_instr_word,
  input  logic [63:0] in_place_addr,
  input  logic [63:0] in_target_addr,
  output dec_t        dec
);

  dec_t dec_r;
  dec_t dec_nxt;

  always_comb begin
    dec_nxt       = dec_r;
    dec_nxt.valid = in_valid;
    dec_nxt.word  = in_instr_word;
    dec_nxt.lo12  = in_target_addr[11:0];
    dec_nxt.op_a  = in_target_addr;
    dec_nxt.op_b  = in_place_addr;
    case (in_action)
      R_CALL26: begin
        dec_nxt.kind = KIND_CALL;
      end
      R_PAGE_HI21: begin
        dec_nxt.kind = KIND_PAGE;
        dec_nxt.op_a = {in_target_addr[63:12], 12'h000};
        dec_nxt.op_b = {in_place_addr[63:12], 12'h000};
      end
      R_ADD_LO12: begin
        dec_nxt.kind = KIND_LO12;
      end
      default: begin
        dec_nxt.kind = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.valid <= 1'b0;
    end else if (adv) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec = dec_r;

endmodule

// ===== rtl/core/arp_sub.sv =====
// Stage 2: form the 64-bit place-relative difference.
// Depends on arp_pkg.
module arp_sub
  import arp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  dec_t dec,
  output sub_t sub
);

  sub_t sub_r;
  sub_t sub_nxt;

  always_comb begin
    sub_nxt.valid = dec.valid;
    sub_nxt.kind  = dec.kind;
    sub_nxt.word  = dec.word;
    sub_nxt.lo12  = dec.lo12;
    sub_nxt.diff  = dec.op_a - dec.op_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r.valid <= 1'b0;
    end else if (adv) begin
      sub_r <= sub_nxt;
    end
  end

  assign sub = sub_r;

endmodule

// ===== rtl/core/arp_patch.sv =====
// Stage 3: range and alignment checks, immediate insertion, output register.
// Depends on arp_pkg.
module arp_patch
  import arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  sub_t        sub,
  output logic        out_valid,
  output logic [31:0] out_patched_word,
  output logic [2:0]  out_status
);

  logic        valid_r;
  logic [31:0] word_r;
  logic [31:0] word_nxt;
  logic [2:0]  status_r;
  logic [2:0]  status_nxt;
  logic        br_fits;
  logic        pg_fits;
  logic        is_add;
  logic [11:0] imm12;

  assign br_fits = (&sub.diff[63:27]) | ~(|sub.diff[63:27]);
  assign pg_fits = (&sub.diff[63:32]) | ~(|sub.diff[63:32]);
  assign is_add  = (sub.word[28:24] == ADD_IMM_OPC);
  assign imm12   = is_add ? sub.lo12 : {2'b00, sub.lo12[11:2]};

  always_comb begin
    word_nxt   = sub.word;
    status_nxt = ST_LO12_FAIL;
    case (sub.kind)
      KIND_CALL: begin
        if (sub.diff[1:0] != 2'b00) begin
          status_nxt = ST_BR_ALIGN;
        end else if (!br_fits) begin
          status_nxt = ST_BR_RANGE;
        end else begin
          status_nxt = ST_OK;
          word_nxt   = (sub.word & BR_KEEP_MASK) | {6'b0, sub.diff[27:2]};
        end
      end
      KIND_PAGE: begin
        if (!pg_fits) begin
          status_nxt = ST_PG_RANGE;
        end else begin
          status_nxt = ST_OK;
          word_nxt   = {sub.word[31], sub.diff[13:12], sub.word[28:24],
                        sub.diff[32:14], sub.word[4:0]};
        end
      end
      KIND_LO12: begin
        if (!is_add && (sub.lo12[1:0] != 2'b00)) begin
          status_nxt = ST_LO12_FAIL;
        end else begin
          status_nxt = ST_OK;
          word_nxt   = {sub.word[31:22], imm12, sub.word[9:0]};
        end
      end
      default: begin
        status_nxt = ST_LO12_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r  <= sub.valid;
      word_r   <= word_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_patched_word = word_r;
  assign out_status       = status_r;

endmodule

// ===== rtl/core/aarch64_reloc_patch.sv =====
// Channel | ports                                             | direction
// in      | in_valid in_stall in_action in_instr_word        | into block
//         | in_place_addr in_target_addr                      |
// out     | out_valid out_stall out_patched_word out_status   | out of block
// Three register stages (decode, 64-bit subtract, check and patch): one word
// per cycle unless the output stalls; a word passes the three registers in order.
// Each stage fills when empty, so in_stall rises only with all three full.
// rst_n is synchronous and clears the stage valid bits only.
// Top level; depends on arp_pkg, arp_decode, arp_sub and arp_patch.
module aarch64_reloc_patch
  import arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_action,
  input  logic [31:0] in_instr_word,
  input  logic [63:0] in_place_addr,
  input  logic [63:0] in_target_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_patched_word,
  output logic [2:0]  out_status
);

  dec_t dec;
  sub_t sub;
  logic adv1;
  logic adv2;
  logic adv3;

  assign adv3     = !out_valid || !out_stall;
  assign adv2     = !sub.valid || adv3;
  assign adv1     = !dec.valid || adv2;
  assign in_stall = !adv1;

  arp_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv1),
    .in_valid       (in_valid),
    .in_action      (in_action),
    .in_instr_word  (in_instr_word),
    .in_place_addr  (in_place_addr),
    .in_target_addr (in_target_addr),
    .dec            (dec)
  );

  arp_sub u_sub (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv2),
    .dec   (dec),
    .sub   (sub)
  );

  arp_patch u_patch (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv3),
    .sub              (sub),
    .out_valid        (out_valid),
    .out_patched_word (out_patched_word),
    .out_status       (out_status)
  );

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (dec.valid && sub.valid && out_valid && out_stall))
    else $error("input stalled with a free stage");

  a_fill_out: assert property (@(posedge clk) disable iff (!rst_n)
    (sub.valid && adv3) |=> out_valid)
    else $error("word lost between subtract and patch stages");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_BR_ALIGN ||
                   out_status == ST_BR_RANGE || out_status == ST_PG_RANGE ||
                   out_status == ST_LO12_FAIL))
    else $error("undefined status code");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !dec.valid && !sub.valid))
    else $error("pipeline not empty after reset");
`endif

endmodule
